[src/salc_pkg.sv]
package salc_pkg;
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS = 8;
  localparam int ADDR_WIDTH = 64;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NWAY_W = $clog2(MAX_WAYS + 1);
  localparam int RANK_W = WAY_W;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SBW = $clog2(MAX_SET_BITS + 1);
  localparam int ROW_W = MAX_WAYS * (1 + RANK_W);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_USED = 2'd2;

  typedef struct packed {
    logic load;
    logic clr_row;
    logic read;
    logic update;
    logic clr_now;
  } salc_cmd_t;

  typedef struct packed {
    logic second;
    logic clr_done;
  } salc_sts_t;
endpackage

[src/set_assoc_lru_cache_model.sv]
// Tag-only set-associative cache with LRU replacement.
// Input channel: in_valid/in_stall with opcode and address; one transfer
// per access item. Output channel: out_valid/out_stall with this item's
// hit count, miss and eviction flags and the saturating running totals.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while idle. Index 0 set_bits, 1 block_bits, 2 ways_used.
// Sequence: a load or store goes from transfer through the set read
// (registered RAM data) and the update of that set to the result; a
// modify updates twice, the second access reusing the forwarded set. An
// unknown opcode goes straight to the result. The next item is taken in
// the cycle the result transfers, so items never overlap; an access waits
// for the registered set read followed by the update of that set.
// After reset the valid/rank RAM is cleared one set per cycle, all
// NUM_SETS (64) sets, during which in_stall is high; configuration
// writes are taken throughout. While the receiver stalls, the result
// is held and no further item is accepted.
module set_assoc_lru_cache_model import salc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            hits_now,
  output logic                  misses_now,
  output logic                  evictions_now,
  output logic [31:0]           total_hits,
  output logic [31:0]           total_misses,
  output logic [31:0]           total_evictions,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_used;
  logic [SBW-1:0] sb;
  logic [NWAY_W-1:0] nways;
  salc_cmd_t cmd;
  salc_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= '0;
      block_bits <= '0;
      ways_used <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg_data[5:0];
        REG_WAYS_USED:  ways_used <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign sb = (32'(set_bits) > MAX_SET_BITS) ? SBW'(MAX_SET_BITS) : SBW'(set_bits);
  assign nways = (ways_used == '0) ? NWAY_W'(1) :
                 ((32'(ways_used) > MAX_WAYS) ? NWAY_W'(MAX_WAYS) : NWAY_W'(ways_used));

  salc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .sts(sts), .cmd(cmd), .in_valid(in_valid),
    .in_opcode(opcode), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall));

  salc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .opcode_in(opcode),
    .address_in(address), .sb(sb), .bb(block_bits), .nways(nways),
    .hits_now(hits_now), .misses_now(misses_now), .evictions_now(evictions_now),
    .total_hits(total_hits), .total_misses(total_misses),
    .total_evictions(total_evictions));
endmodule

[src/salc_ram.sv]
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/salc_datapath.sv]
module salc_datapath import salc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  salc_cmd_t             cmd,
  output salc_sts_t             sts,
  input  logic [1:0]            opcode_in,
  input  logic [ADDR_WIDTH-1:0] address_in,
  input  logic [SBW-1:0]        sb,
  input  logic [5:0]            bb,
  input  logic [NWAY_W-1:0]     nways,
  output logic [1:0]            hits_now,
  output logic                  misses_now,
  output logic                  evictions_now,
  output logic [31:0]           total_hits,
  output logic [31:0]           total_misses,
  output logic [31:0]           total_evictions
);
  logic [1:0] op;
  logic [SET_W-1:0] set_idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [SET_W-1:0] clr_ptr;
  logic [ADDR_WIDTH-1:0] shb, shs;
  logic [6:0] tsh;

  // Address split is registered at load so the shifts stay off the RAM path.
  always_comb begin
    shb = (7'(bb) >= 7'(ADDR_WIDTH)) ? '0 : (address_in >> bb);
    tsh = 7'(bb) + 7'(sb);
    shs = (tsh >= 7'(ADDR_WIDTH)) ? '0 : (address_in >> tsh);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode_in;
      set_idx <= SET_W'(shb) & SET_W'((1 << sb) - 1);
      tag <= shs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clr_row) clr_ptr <= clr_ptr + 1'b1;
  end
  assign sts.clr_done = (clr_ptr == SET_W'(NUM_SETS - 1));
  assign sts.second = (op == OP_MODIFY);

  logic [ROW_W-1:0] row_rd, row_wr;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] tags_rd, tags_wr;
  logic row_we, tag_we;

  salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row (
    .clk(clk), .we(row_we), .waddr(cmd.clr_row ? clr_ptr : set_idx),
    .wdata(row_wr), .raddr(set_idx), .rdata(row_rd));
  salc_ram #(.WIDTH(MAX_WAYS*ADDR_WIDTH), .DEPTH(NUM_SETS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(set_idx), .wdata(tags_wr),
    .raddr(set_idx), .rdata(tags_rd));

  // Both accesses of a modify hit the same set, so row state is forwarded.
  logic [ROW_W-1:0] row_fwd;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] tags_fwd;
  logic fwd;
  logic [MAX_WAYS-1:0] v;
  logic [RANK_W-1:0] rk [MAX_WAYS];
  logic [MAX_WAYS-1:0] v_n;
  logic [RANK_W-1:0] rk_n [MAX_WAYS];
  logic hit, full;
  logic [WAY_W-1:0] way;
  logic [RANK_W:0] old;
  logic [RANK_W-1:0] best;

  always_comb begin
    logic [ROW_W-1:0] r;
    logic [MAX_WAYS*ADDR_WIDTH-1:0] t;
    logic found, inv;
    logic [WAY_W-1:0] iw;
    r = fwd ? row_fwd : row_rd;
    t = fwd ? tags_fwd : tags_rd;
    for (int j = 0; j < MAX_WAYS; j++) begin
      v[j] = r[j*(1+RANK_W)];
      rk[j] = r[j*(1+RANK_W)+1 +: RANK_W];
    end
    found = 1'b0; way = '0; inv = 1'b0; iw = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (NWAY_W'(j) < nways && v[j] && t[j*ADDR_WIDTH +: ADDR_WIDTH] == tag && !found) begin
        found = 1'b1; way = WAY_W'(j);
      end
      if (NWAY_W'(j) < nways && !v[j] && !inv) begin
        inv = 1'b1; iw = WAY_W'(j);
      end
    end
    hit = found;
    full = !found && !inv;
    best = rk[0];
    if (!found) begin
      if (inv) way = iw;
      else begin
        way = '0;
        for (int j = 1; j < MAX_WAYS; j++) begin
          if (NWAY_W'(j) < nways && rk[j] > best) begin
            best = rk[j]; way = WAY_W'(j);
          end
        end
      end
    end
    old = (!found && inv) ? (RANK_W+1)'(MAX_WAYS) : {1'b0, rk[way]};
    v_n = v;
    v_n[way] = 1'b1;
    for (int j = 0; j < MAX_WAYS; j++) begin
      rk_n[j] = rk[j];
      if (NWAY_W'(j) < nways && WAY_W'(j) != way && v[j] && {1'b0, rk[j]} < old
          && rk[j] != RANK_W'(MAX_WAYS - 1))
        rk_n[j] = rk[j] + 1'b1;
    end
    rk_n[way] = '0;
    for (int j = 0; j < MAX_WAYS; j++)
      row_wr[j*(1+RANK_W) +: 1+RANK_W] = {rk_n[j], v_n[j]};
    if (cmd.clr_row) row_wr = '0;
    tags_wr = t;
    tags_wr[way*ADDR_WIDTH +: ADDR_WIDTH] = tag;
  end

  assign row_we = cmd.clr_row || cmd.update;
  assign tag_we = cmd.update && !hit;

  always_ff @(posedge clk) begin
    if (rst) fwd <= 1'b0;
    else if (cmd.update) fwd <= 1'b1;
    else if (cmd.read) fwd <= 1'b0;
    if (cmd.update) begin
      row_fwd <= row_wr;
      tags_fwd <= tags_wr;
    end
  end

  function automatic logic [31:0] sat(input logic [31:0] x, input logic inc);
    return (inc && x != '1) ? x + 32'd1 : x;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_now <= '0; misses_now <= 1'b0; evictions_now <= 1'b0;
      total_hits <= '0; total_misses <= '0; total_evictions <= '0;
    end else begin
      if (cmd.clr_now) begin
        hits_now <= '0; misses_now <= 1'b0; evictions_now <= 1'b0;
      end
      if (cmd.update) begin
        hits_now <= hits_now + 2'(hit);
        misses_now <= misses_now | !hit;
        evictions_now <= evictions_now | full;
        total_hits <= sat(total_hits, hit);
        total_misses <= sat(total_misses, !hit);
        total_evictions <= sat(total_evictions, full);
      end
    end
  end
endmodule

[src/salc_ctrl.sv]
module salc_ctrl import salc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  salc_sts_t sts,
  output salc_cmd_t cmd,
  input  logic      in_valid,
  input  logic [1:0] in_opcode,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall
);
  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic pass2, pass2_next;
  logic acc;

  assign in_stall = !(state == S_IDLE || (state == S_OUT && !out_stall));
  assign out_valid = (state == S_OUT);
  assign acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    pass2_next = pass2;
    cmd = '0;
    case (state)
      S_CLR: begin
        cmd.clr_row = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE, S_OUT: begin
        if (state == S_OUT && !out_stall) state_next = S_IDLE;
        if (acc) begin
          cmd.load = 1'b1;
          cmd.clr_now = 1'b1;
          pass2_next = 1'b0;
          // An unknown opcode makes no access and reports straight away.
          state_next = (in_opcode == OP_NONE) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        cmd.read = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (sts.second && !pass2) begin
          pass2_next = 1'b1;
          state_next = S_UPD;
        end else state_next = S_OUT;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      pass2 <= pass2_next;
    end
  end
endmodule
